/* rtl/core/sine_period_tone_generator_top_defines.svh */
// Assertion shorthands for the tone generator datapath.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef SINE_PERIOD_TONE_GENERATOR_TOP_DEFINES_SVH
`define SINE_PERIOD_TONE_GENERATOR_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define SPTG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SPTG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sptg_pkg.sv */
`timescale 1ns / 1ps
package sptg_pkg;

    // defaults for the top-level parameters
    localparam int DEF_PERIOD_DEPTH = 1024;
    localparam int DEF_MIN_PERIOD   = 16;

    // field widths
    localparam int OP_W       = 2;
    localparam int FREQ_W     = 24;
    localparam int SAMPLE_W   = 12;
    localparam int RATE_W     = 16;
    localparam int AMP_W      = 11;
    localparam int MID_W      = 12;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;

    // configuration reset values
    localparam logic [RATE_W-1:0] RST_RATE = RATE_W'(16000);
    localparam logic [AMP_W-1:0]  RST_AMP  = AMP_W'(1365);
    localparam logic [MID_W-1:0]  RST_MID  = MID_W'(2048);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RATE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AMP  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MID  = 2'd2;

    // command codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_STOP  = 2'd2
    } t_op;

    // divider: (rate*200 + f) fits 25 bits, as does 2*f
    localparam int DIV_W    = 25;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int RATE_MUL = 200;

    // phase and sine table
    localparam int PHASE_W     = 12;
    localparam int PHASE_STEPS = 4096;
    localparam int QTR_W       = 10;
    localparam int QTR_STEPS   = 1024;
    localparam int QTAB_LEN    = QTR_STEPS + 1;
    localparam int QIDX_W      = 11;
    localparam int MAG_W       = 15;
    localparam int PROD_W      = AMP_W + MAG_W;
    localparam int SUM_W       = 14;
    localparam int SAMPLE_MAX  = 4095;

    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] LOW32      = 64'h00000000FFFFFFFF;
    localparam int          SINE_PEAK  = 32767;
    localparam int          TAYLOR_TERMS = 13;

    typedef logic [MAG_W-1:0] t_qtab [0:QTAB_LEN-1];

    // controller to datapath
    typedef struct packed {
        logic div_n;       // start divide for the period length
        logic set_len;     // latch the clamped period length
        logic div_ph;      // start divide for the phase step
        logic fill_start;  // start filling the store
        logic tick_rd;     // read the store at the play position
        logic stop;        // halt playback
        logic emit_start;  // load the start result
        logic emit_tick;   // load the tick result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic fill_done;
        logic playing;
        logic out_free;
    } t_stat;

    // (a * b) >> 60 on unsigned Q60 values
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
        a0  = a & LOW32;
        a1  = a >> 32;
        b0  = b & LOW32;
        b1  = b >> 32;
        p00 = a0 * b0;
        p01 = a0 * b1;
        p10 = a1 * b0;
        p11 = a1 * b1;
        mid = (p00 >> 32) + (p01 & LOW32) + (p10 & LOW32);
        lo  = (p00 & LOW32) | (mid << 32);
        hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
        return (hi << 4) | (lo >> 60);
    endfunction

    // quarter-wave unsigned Q0.15 sine, Taylor series in Q60; evaluated at elaboration
    function automatic t_qtab build_qtab();
        t_qtab       tab;
        logic [63:0] step, x, x2, term, pos, neg, s, v;
        int unsigned p, k;
        step = PI_Q60 >> 11;
        for (p = 0; p < QTAB_LEN; p++) begin
            x    = step * 64'(p);
            x2   = mul_q60(x, x);
            term = x;
            pos  = x;
            neg  = '0;
            for (k = 1; k <= TAYLOR_TERMS; k++) begin
                term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
                if (k[0]) neg = neg + term;
                else pos = pos + term;
            end
            s = (pos >= neg) ? pos - neg : 64'd0;
            v = ((s >> 20) * 64'(SINE_PEAK) + (64'd1 << 39)) >> 40;
            if (v > 64'(SINE_PEAK)) v = 64'(SINE_PEAK);
            tab[p] = v[MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_qtab QSINE = build_qtab();

endpackage

/* rtl/core/sine_period_tone_generator_top.sv */
// Sine period tone generator: one item in flight at a time.
// Start: two 25-step divider passes (period length, then phase step), then one store write
//   per cycle through a four-stage sine pipeline, then the result is loaded.
// Tick: store read, then load; stop and ignored ticks take the transfer cycle.
// Next transfer in the cycle after the result is loaded; a held result stalls the input.
// Reset: synchronous, active low; registers to defaults, playback off, store not cleared.
`timescale 1ns / 1ps
module sine_period_tone_generator_top import sptg_pkg::*; #(
    parameter  int PERIOD_DEPTH = DEF_PERIOD_DEPTH,
    parameter  int MIN_PERIOD   = DEF_MIN_PERIOD,
    localparam int LW           = $clog2(PERIOD_DEPTH + 1),
    localparam int OUT_W        = ((SAMPLE_W + LW + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [FREQ_W-1:0]     i_s_axis_tdata,   // [23:0] freq_centihz
    input  logic [OP_W-1:0]       i_s_axis_tuser,   // [1:0] op
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_W-1:0]      o_m_axis_tdata,   // sample, period_len, zero fill
    output logic                  o_m_axis_tlast,   // period_wrap
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    t_cmd                cmd;
    t_stat               stat;
    logic [SAMPLE_W-1:0] sample;
    logic [LW-1:0]       period_len;

    sptg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sptg_datapath #(
        .PERIOD_DEPTH (PERIOD_DEPTH),
        .MIN_PERIOD   (MIN_PERIOD)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_freq        (i_s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_sample      (sample),
        .o_period_len  (period_len),
        .o_period_wrap (o_m_axis_tlast)
    );

    // pack result fields, sample in the low bits
    assign o_m_axis_tdata = OUT_W'({period_len, sample});

endmodule

/* rtl/core/sptg_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// A zero divisor gives an all-ones quotient.
module sptg_div import sptg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient,
    output logic [DIV_W-1:0] o_remainder
);

    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo, r_rem, r_dvs;
    logic [DIV_W:0]       rem_shift, rem_sub;
    logic                 ge;

    // trial subtract
    assign rem_shift = {r_rem, r_quo[DIV_W-1]};
    assign rem_sub   = rem_shift - {1'b0, r_dvs};
    assign ge        = rem_shift >= {1'b0, r_dvs};

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // partial remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* rtl/core/sptg_datapath.sv */
`timescale 1ns / 1ps
`include "sine_period_tone_generator_top_defines.svh"
// Configuration, period sizing, store fill pipeline, playback and result register.
module sptg_datapath import sptg_pkg::*; #(
    parameter  int PERIOD_DEPTH = DEF_PERIOD_DEPTH,
    parameter  int MIN_PERIOD   = DEF_MIN_PERIOD,
    localparam int AW           = $clog2(PERIOD_DEPTH),
    localparam int LW           = $clog2(PERIOD_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic [FREQ_W-1:0]     i_freq,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [SAMPLE_W-1:0]   o_sample,
    output logic [LW-1:0]         o_period_len,
    output logic                  o_period_wrap
);

    // configuration registers
    logic [RATE_W-1:0] r_rate;
    logic [AMP_W-1:0]  r_amp;
    logic [MID_W-1:0]  r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RST_RATE;
            r_amp  <= RST_AMP;
            r_mid  <= RST_MID;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RATE: r_rate <= i_cfg_wdata[RATE_W-1:0];
                REG_AMP:  r_amp  <= i_cfg_wdata[AMP_W-1:0];
                REG_MID:  r_mid  <= i_cfg_wdata[MID_W-1:0];
                default:  ;
            endcase
        end
    end

    // shared divider: period length, then phase step
    logic [DIV_W-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic             div_done;
    logic [LW-1:0]    r_len;

    always_comb begin
        if (i_cmd.div_ph) begin
            div_dividend = DIV_W'(PHASE_STEPS);
            div_divisor  = DIV_W'(r_len);
        end else begin
            // round(rate*100 / f) as (2*rate*100 + f) / (2*f)
            div_dividend = DIV_W'(r_rate) * DIV_W'(RATE_MUL) + DIV_W'(i_freq);
            div_divisor  = DIV_W'({i_freq, 1'b0});
        end
    end

    sptg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_n | i_cmd.div_ph),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // clamp of the period length
    logic [LW-1:0] len_clamp;
    always_comb begin
        priority if (div_quo < DIV_W'(MIN_PERIOD)) len_clamp = LW'(MIN_PERIOD);
        else if (div_quo > DIV_W'(PERIOD_DEPTH))   len_clamp = LW'(PERIOD_DEPTH);
        else                                       len_clamp = div_quo[LW-1:0];
    end

    // playback state
    logic [AW-1:0] r_pos, pos_w, tick_next;
    logic [LW-1:0] pos_inc;
    logic          r_playing, tick_last;

    assign pos_w     = (LW'(r_pos) >= r_len) ? '0 : r_pos;
    assign pos_inc   = LW'(pos_w) + LW'(1);
    assign tick_last = pos_inc >= r_len;
    assign tick_next = tick_last ? '0 : pos_inc[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LW'(MIN_PERIOD);
            r_pos     <= '0;
            r_playing <= 1'b0;
        end else begin
            if (i_cmd.set_len) begin
                r_len <= len_clamp;
                r_pos <= '0;
            end
            if (i_cmd.fill_start) r_playing <= 1'b1;
            if (i_cmd.stop) r_playing <= 1'b0;
            if (i_cmd.tick_rd) r_pos <= tick_next;
        end
    end

    // phase generator: p = floor(i*4096/N) kept as quotient step plus fraction
    logic [PHASE_W-1:0] r_q0, r_phase;
    logic [LW-1:0]      r_r0, r_frac;
    logic [LW:0]        frac_sum;
    logic [AW-1:0]      r_gen_idx;
    logic               r_gen_act;

    assign frac_sum = {1'b0, r_frac} + {1'b0, r_r0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_act <= 1'b0;
        end else if (i_cmd.fill_start) begin
            r_gen_act <= 1'b1;
        end else if (r_gen_act) begin
            r_gen_act <= LW'(r_gen_idx) != (r_len - LW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_start) begin
            r_q0      <= div_quo[PHASE_W-1:0];
            r_r0      <= div_rem[LW-1:0];
            r_gen_idx <= '0;
            r_phase   <= '0;
            r_frac    <= '0;
        end else if (r_gen_act) begin
            r_gen_idx <= r_gen_idx + 1'b1;
            if (frac_sum >= {1'b0, r_len}) begin
                r_frac  <= LW'(frac_sum - {1'b0, r_len});
                r_phase <= r_phase + r_q0 + PHASE_W'(1);
            end else begin
                r_frac  <= frac_sum[LW-1:0];
                r_phase <= r_phase + r_q0;
            end
        end
    end

    // quarter-wave lookup by quadrant
    logic [1:0]        quad;
    logic [QTR_W-1:0]  qtr;
    logic [QIDX_W-1:0] rom_idx;

    assign quad    = r_phase[PHASE_W-1 -: 2];
    assign qtr     = r_phase[QTR_W-1:0];
    assign rom_idx = quad[0] ? QIDX_W'(QTR_STEPS) - {1'b0, qtr} : {1'b0, qtr};

    // stage B: registered table read
    logic              r_b_vld, r_b_neg;
    logic [MAG_W-1:0]  r_b_mag;
    logic [AW-1:0]     r_b_addr;
    // stage C: scaled deviation
    logic              r_c_vld, r_c_neg;
    logic [AMP_W-1:0]  r_c_dev;
    logic [AW-1:0]     r_c_addr;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(r_amp) * PROD_W'(r_b_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_b_vld <= r_gen_act;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mag  <= QSINE[rom_idx];
        r_b_neg  <= quad[1];
        r_b_addr <= r_gen_idx;
        r_c_dev  <= prod[PROD_W-1 -: AMP_W];
        r_c_neg  <= r_b_neg;
        r_c_addr <= r_b_addr;
    end

    // stage D: offset by midscale and clamp to the DAC range
    logic signed [SUM_W-1:0] mid_s, dev_s, sum;
    logic [SAMPLE_W-1:0]     wr_data;

    assign mid_s = $signed(SUM_W'(r_mid));
    assign dev_s = $signed(SUM_W'(r_c_dev));
    assign sum   = r_c_neg ? mid_s - dev_s : mid_s + dev_s;

    always_comb begin
        priority if (sum < 0)                         wr_data = '0;
        else if (sum > $signed(SUM_W'(SAMPLE_MAX)))   wr_data = SAMPLE_W'(SAMPLE_MAX);
        else                                          wr_data = sum[SAMPLE_W-1:0];
    end

    // period store
    logic [SAMPLE_W-1:0] r_store [0:PERIOD_DEPTH-1];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_tick_last;

    always_ff @(posedge i_clk) begin
        if (r_c_vld) r_store[r_c_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_rd) begin
            r_rd_data   <= r_store[pos_w];
            r_tick_last <= tick_last;
        end
    end

    // result register
    logic                r_out_valid, r_out_last;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [LW-1:0]       r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_start | i_cmd.emit_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_out_sample <= '0;
            r_out_len    <= r_len;
            r_out_last   <= 1'b0;
        end else if (i_cmd.emit_tick) begin
            r_out_sample <= r_rd_data;
            r_out_len    <= r_len;
            r_out_last   <= r_tick_last;
        end
    end

    // status
    assign o_stat.div_done  = div_done;
    assign o_stat.fill_done = !r_gen_act && !r_b_vld && !r_c_vld;
    assign o_stat.playing   = r_playing;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_sample      = r_out_sample;
    assign o_period_len  = r_out_len;
    assign o_period_wrap = r_out_last;

    `SPTG_ASSERT_ALWAYS(a_len_range, (r_len >= LW'(MIN_PERIOD)) && (r_len <= LW'(PERIOD_DEPTH)), "period length out of range")
    `SPTG_ASSERT_ALWAYS(a_pos_in_period, LW'(r_pos) < r_len, "play position beyond period")
    `SPTG_ASSERT_IMPL(a_wr_in_period, r_c_vld, LW'(r_c_addr) < r_len, "store write beyond period")
    `SPTG_ASSERT_IMPL(a_frac_below_len, r_gen_act, r_frac < r_len, "phase fraction not reduced")

endmodule

/* rtl/core/sptg_ctrl.sv */
`timescale 1ns / 1ps
// Command sequencer: one item at a time, results held until the output is free.
module sptg_ctrl import sptg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_in_op,
    output logic            o_in_ready,
    input  t_stat           i_stat,
    output t_cmd            o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIVN  = 7'b0000010,
        S_PHGO  = 7'b0000100,
        S_DIVPH = 7'b0001000,
        S_FILL  = 7'b0010000,
        S_TRD   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_start, n_is_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_is_start <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_is_start <= n_is_start;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_is_start = r_is_start;
        o_cmd      = '0;
        o_in_ready = r_state == S_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_op)
                        OP_START: begin
                            o_cmd.div_n = 1'b1;
                            n_is_start  = 1'b1;
                            n_state     = S_DIVN;
                        end
                        OP_TICK: begin
                            if (i_stat.playing) begin
                                o_cmd.tick_rd = 1'b1;
                                n_is_start    = 1'b0;
                                n_state       = S_TRD;
                            end
                        end
                        OP_STOP: o_cmd.stop = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_DIVN: begin
                if (i_stat.div_done) begin
                    o_cmd.set_len = 1'b1;
                    n_state       = S_PHGO;
                end
            end
            S_PHGO: begin
                o_cmd.div_ph = 1'b1;
                n_state      = S_DIVPH;
            end
            S_DIVPH: begin
                if (i_stat.div_done) begin
                    o_cmd.fill_start = 1'b1;
                    n_state          = S_FILL;
                end
            end
            S_FILL: begin
                if (i_stat.fill_done) n_state = S_EMIT;
            end
            S_TRD: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_start = r_is_start;
                    o_cmd.emit_tick  = !r_is_start;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
